// ===== sv/mwm_pkg.sv =====
// Mecanum wheel mixer package: widths, queue depths, wheel indexes and the
// structs passed between the front, the command queue and the back.
// No dependencies.
package mwm_pkg;

   localparam int IN_W        = 9;
   localparam int SUM_W       = 11;
   localparam int MAG_W       = 10;
   localparam int DUTY_W      = 8;
   localparam int REM_W       = 18;
   localparam int WHEELS      = 4;
   localparam int DIV_STEPS   = 8;
   localparam int DIV_STAGES  = DIV_STEPS + 1;
   localparam int WHEEL_LIMIT = 255;

   localparam int WHEEL_FL = 0;
   localparam int WHEEL_FR = 1;
   localparam int WHEEL_RL = 2;
   localparam int WHEEL_RR = 3;

   localparam int CMD_DEPTH  = 4;
   localparam int CMD_PTR_W  = 2;
   localparam int CMD_CNT_W  = 3;

   localparam int OUT_DEPTH  = 16;
   localparam int OUT_PTR_W  = 4;
   localparam int OUT_CNT_W  = 5;

   typedef struct packed {
      logic                               scale;
      logic [WHEELS-1:0]                  neg;
      logic [WHEELS-1:0][MAG_W-1:0]       mag;
      logic [MAG_W-1:0]                   top;
   } cmd_type;

   typedef struct packed {
      logic [WHEELS-1:0]                  dir;
      logic [WHEELS-1:0][DUTY_W-1:0]      duty;
   } rsp_type;

   typedef struct packed {
      logic [OUT_CNT_W-1:0]               occ;
      logic [OUT_CNT_W-1:0]               out_count;
   } bk_status_type;

endpackage

// ===== sv/mwm_front.sv =====
// Mecanum wheel mixer front: accepts drive requests, forms the four wheel
// sums and their magnitudes, finds the largest and classifies scaling.
// Depends on mwm_pkg.
module mwm_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic signed [mwm_pkg::IN_W-1:0]    req_strafe,
   input  logic signed [mwm_pkg::IN_W-1:0]    req_forward,
   input  logic signed [mwm_pkg::IN_W-1:0]    req_turn,
   input  logic [mwm_pkg::CMD_CNT_W-1:0]      cmd_count,
   output logic                               cmd_push,
   output mwm_pkg::cmd_type                   cmd_data
);

   logic signed [mwm_pkg::SUM_W-1:0]                 x;
   logic signed [mwm_pkg::SUM_W-1:0]                 y;
   logic signed [mwm_pkg::SUM_W-1:0]                 r;
   logic signed [mwm_pkg::SUM_W-1:0]                 sum [mwm_pkg::WHEELS];
   logic signed [mwm_pkg::SUM_W-1:0]                 abs_val [mwm_pkg::WHEELS];
   logic [mwm_pkg::WHEELS-1:0]                       neg_in;
   logic [mwm_pkg::WHEELS-1:0][mwm_pkg::MAG_W-1:0]   mag_in;
   logic [mwm_pkg::WHEELS-1:0]                       neg_ff;
   logic [mwm_pkg::WHEELS-1:0][mwm_pkg::MAG_W-1:0]   mag_ff;
   logic                                             s1_valid_ff;
   logic                                             accept;
   logic [mwm_pkg::MAG_W-1:0]                        top01;
   logic [mwm_pkg::MAG_W-1:0]                        top23;
   logic [mwm_pkg::MAG_W-1:0]                        top;

   assign req_full = (mwm_pkg::CMD_CNT_W'(s1_valid_ff) + cmd_count)
                     >= mwm_pkg::CMD_CNT_W'(mwm_pkg::CMD_DEPTH);
   assign accept   = req_push && !req_full;

   always_comb begin
      x = mwm_pkg::SUM_W'(req_strafe);
      y = mwm_pkg::SUM_W'(req_forward);
      r = mwm_pkg::SUM_W'(req_turn);
      sum[mwm_pkg::WHEEL_FL] = y + x + r;
      sum[mwm_pkg::WHEEL_FR] = y - x - r;
      sum[mwm_pkg::WHEEL_RL] = y - x + r;
      sum[mwm_pkg::WHEEL_RR] = y + x - r;
      for (int i = 0; i < mwm_pkg::WHEELS; i++) begin
         neg_in[i]  = sum[i][mwm_pkg::SUM_W-1];
         abs_val[i] = neg_in[i] ? -sum[i] : sum[i];
         mag_in[i]  = abs_val[i][mwm_pkg::MAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         neg_ff <= neg_in;
         mag_ff <= mag_in;
      end
   end

   always_comb begin
      top01 = (mag_ff[0] > mag_ff[1]) ? mag_ff[0] : mag_ff[1];
      top23 = (mag_ff[2] > mag_ff[3]) ? mag_ff[2] : mag_ff[3];
      top   = (top01 > top23) ? top01 : top23;
   end

   assign cmd_push       = s1_valid_ff;
   assign cmd_data.scale = top > mwm_pkg::MAG_W'(mwm_pkg::WHEEL_LIMIT);
   assign cmd_data.neg   = neg_ff;
   assign cmd_data.mag   = mag_ff;
   assign cmd_data.top   = top;

endmodule

// ===== sv/mwm_cmd_queue.sv =====
// Mecanum wheel mixer command queue between front and back.
// Depends on mwm_pkg.
module mwm_cmd_queue (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   input  mwm_pkg::cmd_type                   push_data,
   input  logic                               pop,
   output mwm_pkg::cmd_type                   pop_data,
   output logic                               empty,
   output logic [mwm_pkg::CMD_CNT_W-1:0]      count
);

   mwm_pkg::cmd_type                   mem_ff [mwm_pkg::CMD_DEPTH];
   logic [mwm_pkg::CMD_PTR_W-1:0]      wr_ptr_ff;
   logic [mwm_pkg::CMD_PTR_W-1:0]      rd_ptr_ff;
   logic [mwm_pkg::CMD_CNT_W-1:0]      count_ff;
   logic [mwm_pkg::CMD_CNT_W-1:0]      count_in;

   always_comb begin
      case ({push, pop})
         2'b10:   count_in = count_ff + mwm_pkg::CMD_CNT_W'(1);
         2'b01:   count_in = count_ff - mwm_pkg::CMD_CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + mwm_pkg::CMD_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + mwm_pkg::CMD_PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];
   assign empty    = count_ff == '0;
   assign count    = count_ff;

endmodule

// ===== sv/mwm_back.sv =====
// Mecanum wheel mixer back: pipelined restoring divider scaling the four
// wheels, direction/duty encoding and the result queue with credit control.
// Depends on mwm_pkg.
module mwm_back (
   input  logic                               clock,
   input  logic                               reset,
   input  mwm_pkg::cmd_type                   cmd_data,
   input  logic                               cmd_empty,
   output logic                               cmd_pop,
   input  logic                               rsp_pop,
   output logic                               rsp_empty,
   output mwm_pkg::rsp_type                   rsp_data,
   output mwm_pkg::bk_status_type             status
);

   logic                               launch;
   logic                               out_pop;
   logic                               out_push;
   logic [mwm_pkg::DIV_STEPS:0]        valid_ff;

   logic [mwm_pkg::REM_W-1:0]   rem_ff   [mwm_pkg::DIV_STAGES][mwm_pkg::WHEELS];
   logic [mwm_pkg::REM_W-1:0]   rem_in   [mwm_pkg::DIV_STAGES][mwm_pkg::WHEELS];
   logic [mwm_pkg::DUTY_W-1:0]  quo_ff   [mwm_pkg::DIV_STAGES][mwm_pkg::WHEELS];
   logic [mwm_pkg::DUTY_W-1:0]  quo_in   [mwm_pkg::DIV_STAGES][mwm_pkg::WHEELS];
   logic [mwm_pkg::DUTY_W-1:0]  small_ff [mwm_pkg::DIV_STAGES][mwm_pkg::WHEELS];
   logic [mwm_pkg::DUTY_W-1:0]  small_in [mwm_pkg::DIV_STAGES][mwm_pkg::WHEELS];
   logic [mwm_pkg::MAG_W-1:0]   div_ff   [mwm_pkg::DIV_STAGES];
   logic [mwm_pkg::MAG_W-1:0]   div_in   [mwm_pkg::DIV_STAGES];
   logic [mwm_pkg::WHEELS-1:0]  neg_ff   [mwm_pkg::DIV_STAGES];
   logic [mwm_pkg::WHEELS-1:0]  neg_in   [mwm_pkg::DIV_STAGES];
   logic                        scale_ff [mwm_pkg::DIV_STAGES];
   logic                        scale_in [mwm_pkg::DIV_STAGES];

   mwm_pkg::rsp_type                                  out_entry;
   mwm_pkg::rsp_type                                  out_mem_ff [mwm_pkg::OUT_DEPTH];
   logic [mwm_pkg::OUT_PTR_W-1:0]                     out_wr_ff;
   logic [mwm_pkg::OUT_PTR_W-1:0]                     out_rd_ff;
   logic [mwm_pkg::OUT_CNT_W-1:0]                     out_count_ff;
   logic [mwm_pkg::OUT_CNT_W-1:0]                     out_count_in;
   logic [mwm_pkg::OUT_CNT_W-1:0]                     occ_ff;
   logic [mwm_pkg::OUT_CNT_W-1:0]                     occ_in;

   assign launch   = !cmd_empty && (occ_ff < mwm_pkg::OUT_CNT_W'(mwm_pkg::OUT_DEPTH));
   assign cmd_pop  = launch;
   assign out_push = valid_ff[mwm_pkg::DIV_STEPS];
   assign out_pop  = rsp_pop && !rsp_empty;

   always_comb begin
      logic [mwm_pkg::REM_W:0]   trial;
      logic [mwm_pkg::REM_W-1:0] dsh;
      trial = '0;
      dsh   = '0;
      div_in[0]   = cmd_data.top;
      neg_in[0]   = cmd_data.neg;
      scale_in[0] = cmd_data.scale;
      for (int w = 0; w < mwm_pkg::WHEELS; w++) begin
         rem_in[0][w]   = {cmd_data.mag[w], mwm_pkg::DUTY_W'(0)}
                          - mwm_pkg::REM_W'(cmd_data.mag[w]);
         quo_in[0][w]   = '0;
         small_in[0][w] = cmd_data.mag[w][mwm_pkg::DUTY_W-1:0];
      end
      for (int k = 1; k < mwm_pkg::DIV_STAGES; k++) begin
         div_in[k]   = div_ff[k-1];
         neg_in[k]   = neg_ff[k-1];
         scale_in[k] = scale_ff[k-1];
         for (int w = 0; w < mwm_pkg::WHEELS; w++) begin
            small_in[k][w] = small_ff[k-1][w];
            dsh   = mwm_pkg::REM_W'(div_ff[k-1]) << (mwm_pkg::DIV_STEPS - k);
            trial = {1'b0, rem_ff[k-1][w]} - {1'b0, dsh};
            if (!trial[mwm_pkg::REM_W]) begin
               rem_in[k][w] = trial[mwm_pkg::REM_W-1:0];
               quo_in[k][w] = quo_ff[k-1][w]
                              | (mwm_pkg::DUTY_W'(1) << (mwm_pkg::DIV_STEPS - k));
            end else begin
               rem_in[k][w] = rem_ff[k-1][w];
               quo_in[k][w] = quo_ff[k-1][w];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[mwm_pkg::DIV_STEPS-1:0], launch};
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < mwm_pkg::DIV_STAGES; k++) begin
         div_ff[k]   <= div_in[k];
         neg_ff[k]   <= neg_in[k];
         scale_ff[k] <= scale_in[k];
         for (int w = 0; w < mwm_pkg::WHEELS; w++) begin
            rem_ff[k][w]   <= rem_in[k][w];
            quo_ff[k][w]   <= quo_in[k][w];
            small_ff[k][w] <= small_in[k][w];
         end
      end
   end

   always_comb begin
      logic [mwm_pkg::DUTY_W-1:0] m;
      logic                       rev;
      m   = '0;
      rev = 1'b0;
      for (int w = 0; w < mwm_pkg::WHEELS; w++) begin
         m   = scale_ff[mwm_pkg::DIV_STEPS] ? quo_ff[mwm_pkg::DIV_STEPS][w]
                                            : small_ff[mwm_pkg::DIV_STEPS][w];
         rev = neg_ff[mwm_pkg::DIV_STEPS][w] && (m != '0);
         out_entry.dir[w]  = !rev;
         out_entry.duty[w] = rev ? m : ~m;
      end
   end

   always_comb begin
      case ({out_push, out_pop})
         2'b10:   out_count_in = out_count_ff + mwm_pkg::OUT_CNT_W'(1);
         2'b01:   out_count_in = out_count_ff - mwm_pkg::OUT_CNT_W'(1);
         default: out_count_in = out_count_ff;
      endcase
      case ({launch, out_pop})
         2'b10:   occ_in = occ_ff + mwm_pkg::OUT_CNT_W'(1);
         2'b01:   occ_in = occ_ff - mwm_pkg::OUT_CNT_W'(1);
         default: occ_in = occ_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff    <= '0;
         out_rd_ff    <= '0;
         out_count_ff <= '0;
         occ_ff       <= '0;
      end else begin
         if (out_push) begin
            out_wr_ff <= out_wr_ff + mwm_pkg::OUT_PTR_W'(1);
         end
         if (out_pop) begin
            out_rd_ff <= out_rd_ff + mwm_pkg::OUT_PTR_W'(1);
         end
         out_count_ff <= out_count_in;
         occ_ff       <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_mem_ff[out_wr_ff] <= out_entry;
      end
   end

   assign rsp_empty        = out_count_ff == '0;
   assign rsp_data         = out_mem_ff[out_rd_ff];
   assign status.occ       = occ_ff;
   assign status.out_count = out_count_ff;

endmodule

// ===== sv/mecanum_wheel_mixer_core.sv =====
// Mecanum wheel mixer top level: front, command queue and back.
// Depends on mwm_pkg, mwm_front, mwm_cmd_queue and mwm_back.
//
// Usage:
//   Requests enter through a queue-style port: a request (strafe, forward,
//   turn) is taken at a rising edge where req_push is high and req_full low.
//   Results leave through a queue-style port: the oldest result sits on the
//   rsp_ ports while rsp_empty is low and is taken at an edge where rsp_pop
//   is high and rsp_empty low. One result per request, in request order.
//   The path from request to rsp_empty falling runs through one sum/max
//   stage, one command queue slot, a launch stage and eight quotient-bit
//   stages of the scaling divider.
//   Throughput: one request per cycle while result credit is free, set by
//   the fully pipelined divider with one quotient bit per stage.
//   A 16-entry result queue is shared by credit with the divider pipeline:
//   when the receiver stalls, the pipeline stops launching, the 4-entry
//   command queue fills and req_full rises. Nothing is dropped.
//   Reset (synchronous, active high) empties both queues and the pipeline;
//   the block holds no other state.
module mecanum_wheel_mixer_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic signed [mwm_pkg::IN_W-1:0]    req_strafe,
   input  logic signed [mwm_pkg::IN_W-1:0]    req_forward,
   input  logic signed [mwm_pkg::IN_W-1:0]    req_turn,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic                               rsp_fl_dir,
   output logic [mwm_pkg::DUTY_W-1:0]         rsp_fl_duty,
   output logic                               rsp_fr_dir,
   output logic [mwm_pkg::DUTY_W-1:0]         rsp_fr_duty,
   output logic                               rsp_rl_dir,
   output logic [mwm_pkg::DUTY_W-1:0]         rsp_rl_duty,
   output logic                               rsp_rr_dir,
   output logic [mwm_pkg::DUTY_W-1:0]         rsp_rr_duty
);

   logic                               cmd_push;
   logic                               cmd_pop;
   logic                               cmd_empty;
   logic [mwm_pkg::CMD_CNT_W-1:0]      cmd_count;
   mwm_pkg::cmd_type                   cmd_wr_data;
   mwm_pkg::cmd_type                   cmd_rd_data;
   mwm_pkg::rsp_type                   rsp_data;
   mwm_pkg::bk_status_type             bk_status;

   mwm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_strafe  (req_strafe),
      .req_forward (req_forward),
      .req_turn    (req_turn),
      .cmd_count   (cmd_count),
      .cmd_push    (cmd_push),
      .cmd_data    (cmd_wr_data)
   );

   mwm_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_wr_data),
      .pop       (cmd_pop),
      .pop_data  (cmd_rd_data),
      .empty     (cmd_empty),
      .count     (cmd_count)
   );

   mwm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_data  (cmd_rd_data),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .status    (bk_status)
   );

   assign rsp_fl_dir  = rsp_data.dir[mwm_pkg::WHEEL_FL];
   assign rsp_fl_duty = rsp_data.duty[mwm_pkg::WHEEL_FL];
   assign rsp_fr_dir  = rsp_data.dir[mwm_pkg::WHEEL_FR];
   assign rsp_fr_duty = rsp_data.duty[mwm_pkg::WHEEL_FR];
   assign rsp_rl_dir  = rsp_data.dir[mwm_pkg::WHEEL_RL];
   assign rsp_rl_duty = rsp_data.duty[mwm_pkg::WHEEL_RL];
   assign rsp_rr_dir  = rsp_data.dir[mwm_pkg::WHEEL_RR];
   assign rsp_rr_duty = rsp_data.duty[mwm_pkg::WHEEL_RR];

   a_cmd_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> (cmd_count < mwm_pkg::CMD_CNT_W'(mwm_pkg::CMD_DEPTH)))
      else $error("command queue written while full");

   a_credit_covers_queue: assert property (@(posedge clock) disable iff (reset)
      bk_status.occ >= bk_status.out_count)
      else $error("result credit below result queue fill");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> (rsp_empty && !cmd_pop))
      else $error("results present after reset");

endmodule

// ===== tb/mwm_checker.sv =====
// Checker for the mecanum wheel mixer: watches both queue ports, predicts the
// wheel directions and duties of each accepted request and compares results.
// Depends on mwm_pkg.
module mwm_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   input  logic                              req_full,
   input  logic signed [mwm_pkg::IN_W-1:0]   req_strafe,
   input  logic signed [mwm_pkg::IN_W-1:0]   req_forward,
   input  logic signed [mwm_pkg::IN_W-1:0]   req_turn,
   input  logic                              rsp_empty,
   input  logic                              rsp_pop,
   input  logic                              rsp_fl_dir,
   input  logic [mwm_pkg::DUTY_W-1:0]        rsp_fl_duty,
   input  logic                              rsp_fr_dir,
   input  logic [mwm_pkg::DUTY_W-1:0]        rsp_fr_duty,
   input  logic                              rsp_rl_dir,
   input  logic [mwm_pkg::DUTY_W-1:0]        rsp_rl_duty,
   input  logic                              rsp_rr_dir,
   input  logic [mwm_pkg::DUTY_W-1:0]        rsp_rr_duty,
   output int                                fail_count,
   output int                                pending
);
   timeunit 1ns;
   timeprecision 1ps;

   mwm_pkg::rsp_type wheel_q[$];
   mwm_pkg::rsp_type want;
   mwm_pkg::rsp_type got;
   string            wheel_name [mwm_pkg::WHEELS] = '{"fl", "fr", "rl", "rr"};

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   function automatic mwm_pkg::rsp_type mix_wheels(
         input logic signed [mwm_pkg::IN_W-1:0] strafe,
         input logic signed [mwm_pkg::IN_W-1:0] forward,
         input logic signed [mwm_pkg::IN_W-1:0] turn);
      int               x;
      int               y;
      int               r;
      int               peak;
      int               speed [mwm_pkg::WHEELS];
      mwm_pkg::rsp_type res;
      x = int'(strafe);
      y = int'(forward);
      r = int'(turn);
      speed[mwm_pkg::WHEEL_FL] = y + x + r;
      speed[mwm_pkg::WHEEL_FR] = y - x - r;
      speed[mwm_pkg::WHEEL_RL] = y - x + r;
      speed[mwm_pkg::WHEEL_RR] = y + x - r;
      peak = 0;
      for (int i = 0; i < mwm_pkg::WHEELS; i++) begin
         if (speed[i] > peak) peak = speed[i];
         if (-speed[i] > peak) peak = -speed[i];
      end
      for (int i = 0; i < mwm_pkg::WHEELS; i++) begin
         if (peak > mwm_pkg::WHEEL_LIMIT)
            speed[i] = (speed[i] * mwm_pkg::WHEEL_LIMIT) / peak;
         if (speed[i] > mwm_pkg::WHEEL_LIMIT) speed[i] = mwm_pkg::WHEEL_LIMIT;
         if (speed[i] < -mwm_pkg::WHEEL_LIMIT) speed[i] = -mwm_pkg::WHEEL_LIMIT;
         if (speed[i] >= 0) begin
            res.dir[i]  = 1'b1;
            res.duty[i] = mwm_pkg::DUTY_W'(mwm_pkg::WHEEL_LIMIT - speed[i]);
         end else begin
            res.dir[i]  = 1'b0;
            res.duty[i] = mwm_pkg::DUTY_W'(-speed[i]);
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got_v, input int want_v);
      if (fail_count < 50)
         $display("%0t mwm_checker: %s got %0d exp %0d", $realtime, what, got_v, want_v);
      fail_count++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full)
            wheel_q.push_back(mix_wheels(req_strafe, req_forward, req_turn));
         if (rsp_pop && !rsp_empty) begin
            got.dir[mwm_pkg::WHEEL_FL]  = rsp_fl_dir;
            got.duty[mwm_pkg::WHEEL_FL] = rsp_fl_duty;
            got.dir[mwm_pkg::WHEEL_FR]  = rsp_fr_dir;
            got.duty[mwm_pkg::WHEEL_FR] = rsp_fr_duty;
            got.dir[mwm_pkg::WHEEL_RL]  = rsp_rl_dir;
            got.duty[mwm_pkg::WHEEL_RL] = rsp_rl_duty;
            got.dir[mwm_pkg::WHEEL_RR]  = rsp_rr_dir;
            got.duty[mwm_pkg::WHEEL_RR] = rsp_rr_duty;
            if (wheel_q.size() == 0) begin
               report_mismatch("result with no request waiting, fl_duty",
                               int'(got.duty[mwm_pkg::WHEEL_FL]), 0);
            end else begin
               want = wheel_q.pop_front();
               for (int i = 0; i < mwm_pkg::WHEELS; i++) begin
                  if (got.dir[i] !== want.dir[i])
                     report_mismatch({wheel_name[i], "_dir"}, int'(got.dir[i]),
                                     int'(want.dir[i]));
                  if (got.duty[i] !== want.duty[i])
                     report_mismatch({wheel_name[i], "_duty"}, int'(got.duty[i]),
                                     int'(want.duty[i]));
               end
            end
         end
      end
      pending <= wheel_q.size();
   end

endmodule

// ===== tb/tb.sv =====
// Testbench top for mecanum_wheel_mixer_core: clock, reset, request and pop
// stimulus, watchdog and verdict. Needs mwm_pkg, mwm_checker and the core.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_CMDS  = 1200;
   localparam int QUIET_TAIL   = 200;
   localparam int HOLD_START   = 50;
   localparam int HOLD_ITEMS   = 60;
   localparam int HOLD_CYCLES  = 120;
   localparam int STALL_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 20;
   localparam int N_DIRECTED   = 24;

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              req_push;
   logic                              req_full;
   logic signed [mwm_pkg::IN_W-1:0]   req_strafe;
   logic signed [mwm_pkg::IN_W-1:0]   req_forward;
   logic signed [mwm_pkg::IN_W-1:0]   req_turn;
   logic                              rsp_empty;
   logic                              rsp_pop;
   logic                              rsp_fl_dir;
   logic [mwm_pkg::DUTY_W-1:0]        rsp_fl_duty;
   logic                              rsp_fr_dir;
   logic [mwm_pkg::DUTY_W-1:0]        rsp_fr_duty;
   logic                              rsp_rl_dir;
   logic [mwm_pkg::DUTY_W-1:0]        rsp_rl_duty;
   logic                              rsp_rr_dir;
   logic [mwm_pkg::DUTY_W-1:0]        rsp_rr_duty;
   int                                fail_count;
   int                                pending;
   int                                quiet_cycles = 0;
   bit                                idle_on = 1'b1;
   bit                                hold_off_req = 1'b0;

   int directed_cmds [N_DIRECTED][3] = '{
      '{0, 0, 0},        '{255, 255, 255},   '{-255, -255, -255}, '{-256, -256, -256},
      '{-256, 0, 0},     '{0, -256, 0},      '{0, 0, -256},       '{255, 0, 0},
      '{-255, 0, 0},     '{0, 255, 0},       '{0, -255, 0},       '{0, 0, 255},
      '{0, 0, -255},     '{255, 255, 0},     '{255, -255, 255},   '{-256, 255, -256},
      '{1, 1, 1},        '{-1, 0, 0},        '{85, 85, 85},       '{86, 85, 85},
      '{100, -100, 50},  '{-255, 255, -255}, '{0, -1, 1},         '{-128, 127, 64}
   };

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   mecanum_wheel_mixer_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_strafe  (req_strafe),
      .req_forward (req_forward),
      .req_turn    (req_turn),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_fl_dir  (rsp_fl_dir),
      .rsp_fl_duty (rsp_fl_duty),
      .rsp_fr_dir  (rsp_fr_dir),
      .rsp_fr_duty (rsp_fr_duty),
      .rsp_rl_dir  (rsp_rl_dir),
      .rsp_rl_duty (rsp_rl_duty),
      .rsp_rr_dir  (rsp_rr_dir),
      .rsp_rr_duty (rsp_rr_duty)
   );

   mwm_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_strafe  (req_strafe),
      .req_forward (req_forward),
      .req_turn    (req_turn),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_fl_dir  (rsp_fl_dir),
      .rsp_fl_duty (rsp_fl_duty),
      .rsp_fr_dir  (rsp_fr_dir),
      .rsp_fr_duty (rsp_fr_duty),
      .rsp_rl_dir  (rsp_rl_dir),
      .rsp_rl_duty (rsp_rl_duty),
      .rsp_rr_dir  (rsp_rr_dir),
      .rsp_rr_duty (rsp_rr_duty),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   function automatic logic signed [mwm_pkg::IN_W-1:0] pick_axis();
      int extremes [7] = '{-256, -255, -1, 0, 1, 254, 255};
      case ($urandom_range(0, 3))
         0: return mwm_pkg::IN_W'($urandom_range(0, 511));
         1: return mwm_pkg::IN_W'($urandom_range(0, 40) - 20);
         2: return mwm_pkg::IN_W'(extremes[$urandom_range(0, 6)]);
         default: return mwm_pkg::IN_W'($urandom_range(0, 510) - 255);
      endcase
   endfunction

   task automatic send_cmd(input logic signed [mwm_pkg::IN_W-1:0] strafe,
                           input logic signed [mwm_pkg::IN_W-1:0] forward,
                           input logic signed [mwm_pkg::IN_W-1:0] turn);
      req_push    <= 1'b1;
      req_strafe  <= strafe;
      req_forward <= forward;
      req_turn    <= turn;
      do @(posedge clock); while (req_full);
   endtask

   task automatic sender_gap();
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   initial begin
      reset       <= 1'b1;
      req_push    <= 1'b0;
      req_strafe  <= '0;
      req_forward <= '0;
      req_turn    <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < N_DIRECTED; i++) begin
         sender_gap();
         send_cmd(mwm_pkg::IN_W'(directed_cmds[i][0]), mwm_pkg::IN_W'(directed_cmds[i][1]),
                  mwm_pkg::IN_W'(directed_cmds[i][2]));
      end
      for (int i = 0; i < RANDOM_CMDS; i++) begin
         if (i == HOLD_START) hold_off_req = 1'b1;
         if (i >= RANDOM_CMDS - QUIET_TAIL) idle_on = 1'b0;
         if (i < HOLD_START || i >= HOLD_START + HOLD_ITEMS) sender_gap();
         send_cmd(pick_axis(), pick_axis(), pick_axis());
      end
      req_push <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   initial begin
      rsp_pop <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_pop <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

endmodule

// ===== mecanum_wheel_mixer_core.f =====
sv/mwm_pkg.sv
sv/mwm_front.sv
sv/mwm_cmd_queue.sv
sv/mwm_back.sv
sv/mecanum_wheel_mixer_core.sv
tb/mwm_checker.sv
tb/tb.sv
